[sv/efsd_pkg.sv]
// ----------------------------------------------------------------------------
// Earliest-free server dispatch package
// Shared constants, opcodes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package efsd_pkg;

	localparam int DEF_MAX_SERVERS = 1024;
	localparam int DEF_TIME_WIDTH  = 48;

	localparam int IDX_FIELD_W   = 10;
	localparam int SVC_FIELD_W   = 16;
	localparam int START_FIELD_W = 48;
	localparam int CNT_FIELD_W   = 11;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SERVE = 1'b1;

	typedef struct packed {
		logic clear;
		logic load;
		logic start;
		logic issue;
		logic fetch;
		logic update;
	} efsd_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic issue_last;
	} efsd_status_t;

endpackage

[sv/efsd_ctrl.sv]
// ----------------------------------------------------------------------------
// Earliest-free server dispatch controller
// Sequences the clearing pass, loads, the minimum scan and the update, and
// owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module efsd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_opcode,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	output efsd_pkg::efsd_cmd_t    cmd,
	input  efsd_pkg::efsd_status_t status
);
	import efsd_pkg::*;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_UPD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd        = '0;
		cmd.clear  = (state_q == ST_CLR);
		cmd.load   = accept && (in_opcode == OP_LOAD);
		cmd.start  = accept && (in_opcode == OP_SERVE);
		cmd.issue  = (state_q == ST_SCAN);
		cmd.fetch  = (state_q == ST_FETCH);
		cmd.update = (state_q == ST_UPD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					if (status.clr_last)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd.start)
						state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (status.issue_last)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_FETCH;
				ST_FETCH: state_q <= ST_UPD;
				ST_UPD: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[sv/efsd_dp.sv]
// ----------------------------------------------------------------------------
// Earliest-free server dispatch datapath
// Holds the server count register, the next-free and service time memories,
// the scan comparator and the result register.
// ----------------------------------------------------------------------------
module efsd_dp #(
	parameter int MAX_SERVERS = efsd_pkg::DEF_MAX_SERVERS,
	parameter int TIME_WIDTH  = efsd_pkg::DEF_TIME_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [efsd_pkg::CNT_FIELD_W-1:0]     cfg_data,
	input  logic [efsd_pkg::IDX_FIELD_W-1:0]     server_index,
	input  logic [efsd_pkg::SVC_FIELD_W-1:0]     service_time,
	input  efsd_pkg::efsd_cmd_t                  cmd,
	output efsd_pkg::efsd_status_t               status,
	output logic [efsd_pkg::IDX_FIELD_W-1:0]     chosen_server,
	output logic [efsd_pkg::START_FIELD_W-1:0]   start_time,
	output logic                                 time_overflow
);
	import efsd_pkg::*;

	localparam int IDX_W = $clog2(MAX_SERVERS);

	logic [TIME_WIDTH-1:0]  nft_mem [MAX_SERVERS];
	logic [SVC_FIELD_W-1:0] svc_mem [MAX_SERVERS];

	logic [CNT_FIELD_W-1:0] count_q;
	logic [IDX_W-1:0]       clr_idx_q;
	logic [IDX_W-1:0]       scan_idx_q;
	logic [IDX_W-1:0]       last_q;
	logic [IDX_W-1:0]       tag_s1;
	logic                   v_s1;
	logic [TIME_WIDTH-1:0]  rd_s1;
	logic [IDX_W-1:0]       best_idx_q;
	logic [TIME_WIDTH-1:0]  best_q;
	logic                   best_valid_q;
	logic [SVC_FIELD_W-1:0] svc_rd_q;
	logic [IDX_W-1:0]       chosen_q;
	logic [TIME_WIDTH-1:0]  start_q;
	logic                   ovf_q;

	logic [11:0]            ext_in_idx;
	logic [IDX_W-1:0]       load_idx;
	logic                   load_ok;
	logic [IDX_W-1:0]       last_d;
	logic [TIME_WIDTH:0]    sum;
	logic                   ovf;
	logic [TIME_WIDTH-1:0]  new_nft;
	logic [11:0]            ext_chosen;
	logic [63:0]            ext_start;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [TIME_WIDTH-1:0]  wr_data;

	assign ext_in_idx = 12'(server_index);
	assign load_idx   = ext_in_idx[IDX_W-1:0];
	assign load_ok    = (32'(server_index) < MAX_SERVERS);

	always_comb begin
		priority if (count_q == '0)
			last_d = '0;
		else if (32'(count_q) > MAX_SERVERS)
			last_d = IDX_W'(MAX_SERVERS - 1);
		else
			last_d = IDX_W'(count_q - 1'b1);
	end

	assign sum     = {1'b0, best_q} + (TIME_WIDTH + 1)'(svc_rd_q);
	assign ovf     = sum[TIME_WIDTH];
	assign new_nft = ovf ? '1 : sum[TIME_WIDTH-1:0];

	assign status.clr_last   = (clr_idx_q == IDX_W'(MAX_SERVERS - 1));
	assign status.issue_last = (scan_idx_q == last_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = best_idx_q;
		wr_data = new_nft;
		priority if (cmd.clear) begin
			wr_en   = 1'b1;
			wr_addr = clr_idx_q;
			wr_data = '0;
		end else if (cmd.load) begin
			wr_en   = load_ok;
			wr_addr = load_idx;
			wr_data = '0;
		end else if (cmd.update) begin
			wr_en   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			nft_mem[wr_addr] <= wr_data;
		if (cmd.issue)
			rd_s1 <= nft_mem[scan_idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load && load_ok)
			svc_mem[load_idx] <= service_time;
		if (cmd.fetch)
			svc_rd_q <= svc_mem[best_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= CNT_FIELD_W'(1);
			clr_idx_q    <= '0;
			v_s1         <= 1'b0;
			best_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				count_q <= cfg_data;
			if (cmd.clear)
				clr_idx_q <= clr_idx_q + 1'b1;
			v_s1 <= cmd.issue;
			if (cmd.start)
				best_valid_q <= 1'b0;
			else if (v_s1)
				best_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			scan_idx_q <= '0;
			last_q     <= last_d;
		end else if (cmd.issue) begin
			scan_idx_q <= scan_idx_q + 1'b1;
		end
		tag_s1 <= scan_idx_q;
		if (v_s1 && (!best_valid_q || rd_s1 < best_q)) begin
			best_q     <= rd_s1;
			best_idx_q <= tag_s1;
		end
		if (cmd.update) begin
			chosen_q <= best_idx_q;
			start_q  <= best_q;
			ovf_q    <= ovf;
		end
	end

	assign ext_chosen    = 12'(chosen_q);
	assign ext_start     = 64'(start_q);
	assign chosen_server = ext_chosen[IDX_FIELD_W-1:0];
	assign start_time    = ext_start[START_FIELD_W-1:0];
	assign time_overflow = ovf_q;

endmodule

[sv/earliest_free_server_dispatch.sv]
// ----------------------------------------------------------------------------
// Earliest-free server dispatch
// Assigns each customer to the server that becomes free first.
// ----------------------------------------------------------------------------
// A load beat does not occupy the block. A serve beat scans the next-free
// memory one entry per cycle over the active servers and then reads the
// service time, so it occupies the block through the scan, drain, fetch and
// update states (a server count of zero acts as one, and one above
// MAX_SERVERS as MAX_SERVERS), and longer while an earlier result is still
// held by the receiver; the single read port of the next-free memory bounds
// the scan. After reset a clearing pass zeroes every entry of that memory,
// during which input beats are stalled while configuration writes are still taken.
module earliest_free_server_dispatch #(
	parameter int MAX_SERVERS = efsd_pkg::DEF_MAX_SERVERS,
	parameter int TIME_WIDTH  = efsd_pkg::DEF_TIME_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [efsd_pkg::CNT_FIELD_W-1:0]     cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 opcode,
	input  logic [efsd_pkg::IDX_FIELD_W-1:0]     server_index,
	input  logic [efsd_pkg::SVC_FIELD_W-1:0]     service_time,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [efsd_pkg::IDX_FIELD_W-1:0]     chosen_server,
	output logic [efsd_pkg::START_FIELD_W-1:0]   start_time,
	output logic                                 time_overflow
);
	import efsd_pkg::*;

	efsd_cmd_t    cmd;
	efsd_status_t status;

	assign cfg_ready = 1'b1;

	efsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_opcode (opcode),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	efsd_dp #(
		.MAX_SERVERS (MAX_SERVERS),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.server_index  (server_index),
		.service_time  (service_time),
		.cmd           (cmd),
		.status        (status),
		.chosen_server (chosen_server),
		.start_time    (start_time),
		.time_overflow (time_overflow)
	);

	a_serve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode == OP_SERVE |=> in_stall)
		else $error("serve beat did not occupy the block");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a serve in progress");

	a_no_load_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !cmd.load && !cmd.update)
		else $error("memory written during scan");

endmodule
